// File: hdl/svgn_pkg.sv
`default_nettype none
package svgn_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;   // Q16.16; adds do not depend on it
    localparam int CMD_WIDTH   = 5;
    localparam int KIND_WIDTH  = 3;
    localparam int GRP_WIDTH   = CMD_WIDTH - 1;
    localparam int FAM_WIDTH   = 2;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    localparam coord_t COORD_MAX = coord_t'({1'b0, {(COORD_WIDTH-1){1'b1}}});
    localparam coord_t COORD_MIN = coord_t'({1'b1, {(COORD_WIDTH-1){1'b0}}});
    localparam coord_t COORD_ZERO = coord_t'(0);

    // highest valid command code (z)
    localparam logic [CMD_WIDTH-1:0] CMD_LAST = 5'd19;

    // command groups: code >> 1, the low bit marks relative
    localparam logic [GRP_WIDTH-1:0] GRP_MOVE   = 4'd0;
    localparam logic [GRP_WIDTH-1:0] GRP_LINE   = 4'd1;
    localparam logic [GRP_WIDTH-1:0] GRP_HORIZ  = 4'd2;
    localparam logic [GRP_WIDTH-1:0] GRP_VERT   = 4'd3;
    localparam logic [GRP_WIDTH-1:0] GRP_CUBIC  = 4'd4;
    localparam logic [GRP_WIDTH-1:0] GRP_SCUBIC = 4'd5;
    localparam logic [GRP_WIDTH-1:0] GRP_QUAD   = 4'd6;
    localparam logic [GRP_WIDTH-1:0] GRP_SQUAD  = 4'd7;
    localparam logic [GRP_WIDTH-1:0] GRP_ARC    = 4'd8;
    localparam logic [GRP_WIDTH-1:0] GRP_CLOSE  = 4'd9;

    localparam logic [KIND_WIDTH-1:0] KIND_MOVE  = 3'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_LINE  = 3'd1;
    localparam logic [KIND_WIDTH-1:0] KIND_CUBIC = 3'd2;
    localparam logic [KIND_WIDTH-1:0] KIND_QUAD  = 3'd3;
    localparam logic [KIND_WIDTH-1:0] KIND_ARC   = 3'd4;
    localparam logic [KIND_WIDTH-1:0] KIND_CLOSE = 3'd5;

    localparam logic [FAM_WIDTH-1:0] FAM_NONE  = 2'd0;
    localparam logic [FAM_WIDTH-1:0] FAM_CUBIC = 2'd1;
    localparam logic [FAM_WIDTH-1:0] FAM_QUAD  = 2'd2;

    localparam int DATA_BITS  = 9 * COORD_WIDTH + 2;
    localparam int TDATA_BITS = ((DATA_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [CMD_WIDTH-1:0] cmd;
        coord_t               ctrl1_x;
        coord_t               ctrl1_y;
        coord_t               ctrl2_x;
        coord_t               ctrl2_y;
        coord_t               end_x;
        coord_t               end_y;
        coord_t               radius_x;
        coord_t               radius_y;
        coord_t               rotation_angle;
        logic                 large_arc;
        logic                 sweep_cw;
    } item_t;

    typedef struct packed {
        logic [KIND_WIDTH-1:0] seg_kind;
        coord_t                out_c1_x;
        coord_t                out_c1_y;
        coord_t                out_c2_x;
        coord_t                out_c2_y;
        coord_t                out_end_x;
        coord_t                out_end_y;
        coord_t                out_radius_x;
        coord_t                out_radius_y;
        coord_t                out_rotation;
        logic                  out_large_arc;
        logic                  out_sweep;
    } seg_t;

    // handshake between the stages
    typedef struct packed {
        logic fire;     // input register hands its item on this cycle
        logic load;     // a result enters the output register
    } stage_ctl_t;

    // a + b, saturated to the coordinate range
    function automatic coord_t sat_add(input coord_t a, input coord_t b);
        logic [COORD_WIDTH:0] s;
        s = {a[COORD_WIDTH-1], a} + {b[COORD_WIDTH-1], b};
        if (s[COORD_WIDTH] != s[COORD_WIDTH-1])
            sat_add = s[COORD_WIDTH] ? COORD_MIN : COORD_MAX;
        else
            sat_add = coord_t'(s[COORD_WIDTH-1:0]);
    endfunction

    // 2*p - c, saturated
    function automatic coord_t reflect(input coord_t p, input coord_t c);
        logic [COORD_WIDTH+1:0] r;
        r = {p[COORD_WIDTH-1], p, 1'b0} - {{2{c[COORD_WIDTH-1]}}, c};
        if ((r[COORD_WIDTH+1:COORD_WIDTH-1] == 3'b000) ||
            (r[COORD_WIDTH+1:COORD_WIDTH-1] == 3'b111))
            reflect = coord_t'(r[COORD_WIDTH-1:0]);
        else
            reflect = r[COORD_WIDTH+1] ? COORD_MIN : COORD_MAX;
    endfunction

endpackage
`default_nettype wire

// File: hdl/svgn_in_stage.sv
`default_nettype none
module svgn_in_stage (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire svgn_pkg::item_t in_item,
    input  wire logic            fire,
    output logic                 item_valid,
    output svgn_pkg::item_t      item
);

    logic            valid_reg;
    svgn_pkg::item_t item_reg;

    // take a new item when empty or when the held one moves on
    assign in_ready   = !valid_reg || fire;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

endmodule
`default_nettype wire

// File: hdl/svgn_seg_unit.sv
`default_nettype none
module svgn_seg_unit (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            fire,
    input  wire svgn_pkg::item_t item,
    output logic                 seg_ok,
    output svgn_pkg::seg_t       seg
);

    svgn_pkg::coord_t cur_x_reg, cur_y_reg, start_x_reg, start_y_reg;
    svgn_pkg::coord_t cubic_x_reg, cubic_y_reg, quad_x_reg, quad_y_reg;
    logic [svgn_pkg::FAM_WIDTH-1:0] fam_reg;

    svgn_pkg::coord_t cur_x_next, cur_y_next, start_x_next, start_y_next;
    svgn_pkg::coord_t cubic_x_next, cubic_y_next, quad_x_next, quad_y_next;
    logic [svgn_pkg::FAM_WIDTH-1:0] fam_next;

    svgn_pkg::coord_t bx, by, c1x, c1y, c2x, c2y, ex, ey;
    logic [svgn_pkg::GRP_WIDTH-1:0] grp;
    logic update;

    assign seg_ok = (item.cmd <= svgn_pkg::CMD_LAST);
    assign update = fire && seg_ok;
    assign grp    = item.cmd[svgn_pkg::CMD_WIDTH-1:1];

    always_comb begin
        bx  = item.cmd[0] ? cur_x_reg : svgn_pkg::COORD_ZERO;
        by  = item.cmd[0] ? cur_y_reg : svgn_pkg::COORD_ZERO;
        c1x = svgn_pkg::sat_add(bx, item.ctrl1_x);
        c1y = svgn_pkg::sat_add(by, item.ctrl1_y);
        c2x = svgn_pkg::sat_add(bx, item.ctrl2_x);
        c2y = svgn_pkg::sat_add(by, item.ctrl2_y);
        ex  = svgn_pkg::sat_add(bx, item.end_x);
        ey  = svgn_pkg::sat_add(by, item.end_y);

        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        start_x_next = start_x_reg;
        start_y_next = start_y_reg;
        cubic_x_next = cubic_x_reg;
        cubic_y_next = cubic_y_reg;
        quad_x_next  = quad_x_reg;
        quad_y_next  = quad_y_reg;
        fam_next     = svgn_pkg::FAM_NONE;
        seg          = '0;

        unique case (grp)
            svgn_pkg::GRP_MOVE: begin
                seg.seg_kind = svgn_pkg::KIND_MOVE;
                cur_x_next   = ex;
                cur_y_next   = ey;
                start_x_next = ex;
                start_y_next = ey;
            end
            svgn_pkg::GRP_LINE: begin
                seg.seg_kind = svgn_pkg::KIND_LINE;
                cur_x_next   = ex;
                cur_y_next   = ey;
            end
            svgn_pkg::GRP_HORIZ: begin
                seg.seg_kind = svgn_pkg::KIND_LINE;
                cur_x_next   = ex;
            end
            svgn_pkg::GRP_VERT: begin
                seg.seg_kind = svgn_pkg::KIND_LINE;
                cur_y_next   = ey;
            end
            svgn_pkg::GRP_CUBIC: begin
                seg.seg_kind = svgn_pkg::KIND_CUBIC;
                seg.out_c1_x = c1x;
                seg.out_c1_y = c1y;
                cubic_x_next = c2x;
                cubic_y_next = c2y;
                cur_x_next   = ex;
                cur_y_next   = ey;
                fam_next     = svgn_pkg::FAM_CUBIC;
            end
            svgn_pkg::GRP_SCUBIC: begin
                seg.seg_kind = svgn_pkg::KIND_CUBIC;
                if (fam_reg == svgn_pkg::FAM_CUBIC) begin
                    seg.out_c1_x = svgn_pkg::reflect(cur_x_reg, cubic_x_reg);
                    seg.out_c1_y = svgn_pkg::reflect(cur_y_reg, cubic_y_reg);
                end else begin
                    seg.out_c1_x = cur_x_reg;
                    seg.out_c1_y = cur_y_reg;
                end
                cubic_x_next = c2x;
                cubic_y_next = c2y;
                cur_x_next   = ex;
                cur_y_next   = ey;
                fam_next     = svgn_pkg::FAM_CUBIC;
            end
            svgn_pkg::GRP_QUAD: begin
                seg.seg_kind = svgn_pkg::KIND_QUAD;
                quad_x_next  = c1x;
                quad_y_next  = c1y;
                cur_x_next   = ex;
                cur_y_next   = ey;
                fam_next     = svgn_pkg::FAM_QUAD;
            end
            svgn_pkg::GRP_SQUAD: begin
                seg.seg_kind = svgn_pkg::KIND_QUAD;
                if (fam_reg == svgn_pkg::FAM_QUAD) begin
                    quad_x_next = svgn_pkg::reflect(cur_x_reg, quad_x_reg);
                    quad_y_next = svgn_pkg::reflect(cur_y_reg, quad_y_reg);
                end else begin
                    quad_x_next = cur_x_reg;
                    quad_y_next = cur_y_reg;
                end
                cur_x_next   = ex;
                cur_y_next   = ey;
                fam_next     = svgn_pkg::FAM_QUAD;
            end
            svgn_pkg::GRP_ARC: begin
                seg.seg_kind      = svgn_pkg::KIND_ARC;
                seg.out_radius_x  = item.radius_x;
                seg.out_radius_y  = item.radius_y;
                seg.out_rotation  = item.rotation_angle;
                seg.out_large_arc = item.large_arc;
                seg.out_sweep     = item.sweep_cw;
                cur_x_next        = ex;
                cur_y_next        = ey;
            end
            default: begin
                // close, and codes past z which never update
                seg.seg_kind = svgn_pkg::KIND_CLOSE;
                cur_x_next   = start_x_reg;
                cur_y_next   = start_y_reg;
            end
        endcase

        if (seg.seg_kind == svgn_pkg::KIND_CUBIC) begin
            seg.out_c2_x = cubic_x_next;
            seg.out_c2_y = cubic_y_next;
        end
        if (seg.seg_kind == svgn_pkg::KIND_QUAD) begin
            seg.out_c1_x = quad_x_next;
            seg.out_c1_y = quad_y_next;
        end
        seg.out_end_x = cur_x_next;
        seg.out_end_y = cur_y_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            start_x_reg <= '0;
            start_y_reg <= '0;
            cubic_x_reg <= '0;
            cubic_y_reg <= '0;
            quad_x_reg  <= '0;
            quad_y_reg  <= '0;
            fam_reg     <= svgn_pkg::FAM_NONE;
        end else if (update) begin
            cur_x_reg   <= cur_x_next;
            cur_y_reg   <= cur_y_next;
            start_x_reg <= start_x_next;
            start_y_reg <= start_y_next;
            cubic_x_reg <= cubic_x_next;
            cubic_y_reg <= cubic_y_next;
            quad_x_reg  <= quad_x_next;
            quad_y_reg  <= quad_y_next;
            fam_reg     <= fam_next;
        end
    end

    a_close_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        (update && grp == svgn_pkg::GRP_CLOSE) |=>
            (cur_x_reg == start_x_reg && cur_y_reg == start_y_reg &&
             fam_reg == svgn_pkg::FAM_NONE))
        else $error("close did not return to subpath start");

    a_move_sets_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (update && grp == svgn_pkg::GRP_MOVE) |=>
            (start_x_reg == cur_x_reg && start_y_reg == cur_y_reg))
        else $error("move did not set subpath start");

    a_bad_cmd_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && !seg_ok) |=>
            ($stable(cur_x_reg) && $stable(cur_y_reg) && $stable(fam_reg) &&
             $stable(quad_x_reg) && $stable(cubic_x_reg)))
        else $error("unknown command changed state");

    a_fam_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (fam_reg == svgn_pkg::FAM_NONE || fam_reg == svgn_pkg::FAM_CUBIC ||
         fam_reg == svgn_pkg::FAM_QUAD))
        else $error("curve family out of range");

endmodule
`default_nettype wire

// File: hdl/svgn_out_stage.sv
`default_nettype none
module svgn_out_stage (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           load,
    input  wire svgn_pkg::seg_t seg_in,
    input  wire logic           out_ready,
    output logic                out_valid,
    output logic                out_free,
    output svgn_pkg::seg_t      seg_out
);

    logic           valid_reg;
    svgn_pkg::seg_t seg_reg;

    // free when empty or the held item leaves this cycle
    assign out_free  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign seg_out   = seg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            seg_reg <= seg_in;
        end
    end

endmodule
`default_nettype wire

// File: hdl/svg_path_segment_normalizer_top.sv
// Path: an accepted item passes through the input register, then the segment
//   logic into the output register, which drives m_tvalid.
// Throughput: one item per cycle while m_tready stays high; the current point and
//   control point registers in the segment unit update as each known command moves on.
// Reset: synchronous, active low; clears both stage valids, the current point,
//   subpath start, stored control points and curve family.
`default_nettype none
module svg_path_segment_normalizer_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input commands
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y, radius_x, radius_y,
    // rotation_angle, large_arc, sweep_cw, zero pad
    input  wire logic [svgn_pkg::TDATA_BITS-1:0] s_tdata,
    // cmd
    input  wire logic [svgn_pkg::CMD_WIDTH-1:0]  s_tuser,
    // absolute segments
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // out_c1_x, out_c1_y, out_c2_x, out_c2_y, out_end_x, out_end_y,
    // out_radius_x, out_radius_y, out_rotation, out_large_arc, out_sweep, zero pad
    output logic [svgn_pkg::TDATA_BITS-1:0]      m_tdata,
    // seg_kind
    output logic [svgn_pkg::KIND_WIDTH-1:0]      m_tuser
);

    localparam int W = svgn_pkg::COORD_WIDTH;

    svgn_pkg::item_t    in_item;
    svgn_pkg::item_t    item;
    svgn_pkg::seg_t     seg;
    svgn_pkg::seg_t     seg_out;
    svgn_pkg::stage_ctl_t ctl;
    logic               item_valid;
    logic               seg_ok;
    logic               out_free;

    // unpack the input item, first field in the low bits
    always_comb begin
        in_item.cmd            = s_tuser;
        in_item.ctrl1_x        = svgn_pkg::coord_t'(s_tdata[0*W +: W]);
        in_item.ctrl1_y        = svgn_pkg::coord_t'(s_tdata[1*W +: W]);
        in_item.ctrl2_x        = svgn_pkg::coord_t'(s_tdata[2*W +: W]);
        in_item.ctrl2_y        = svgn_pkg::coord_t'(s_tdata[3*W +: W]);
        in_item.end_x          = svgn_pkg::coord_t'(s_tdata[4*W +: W]);
        in_item.end_y          = svgn_pkg::coord_t'(s_tdata[5*W +: W]);
        in_item.radius_x       = svgn_pkg::coord_t'(s_tdata[6*W +: W]);
        in_item.radius_y       = svgn_pkg::coord_t'(s_tdata[7*W +: W]);
        in_item.rotation_angle = svgn_pkg::coord_t'(s_tdata[8*W +: W]);
        in_item.large_arc      = s_tdata[9*W];
        in_item.sweep_cw       = s_tdata[9*W+1];
    end

    // advance the held item whenever the output register can take a result;
    // drop items with unknown commands without a result
    assign ctl.fire = item_valid && out_free;
    assign ctl.load = ctl.fire && seg_ok;

    svgn_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .fire       (ctl.fire),
        .item_valid (item_valid),
        .item       (item)
    );

    svgn_seg_unit u_seg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (ctl.fire),
        .item    (item),
        .seg_ok  (seg_ok),
        .seg     (seg)
    );

    svgn_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (ctl.load),
        .seg_in    (seg),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_free  (out_free),
        .seg_out   (seg_out)
    );

    // pack the result item
    assign m_tuser = seg_out.seg_kind;
    assign m_tdata = {
        {(svgn_pkg::TDATA_BITS - svgn_pkg::DATA_BITS){1'b0}},
        seg_out.out_sweep,
        seg_out.out_large_arc,
        seg_out.out_rotation,
        seg_out.out_radius_y,
        seg_out.out_radius_x,
        seg_out.out_end_y,
        seg_out.out_end_x,
        seg_out.out_c2_y,
        seg_out.out_c2_x,
        seg_out.out_c1_y,
        seg_out.out_c1_x
    };

endmodule
`default_nettype wire

// File: dv/svg_path_segment_normalizer_top_tb.sv
`default_nettype none
module svg_path_segment_normalizer_top_tb;
    import svgn_pkg::*;

    localparam int STALL_LIMIT    = 2000;  // cycles with no item moving on either side
    localparam int TRAIL_CYCLES   = 8;     // margin after the drain for stray results
    localparam int SEGMENT_TARGET = 550;
    localparam int QUIET_FIRST    = 200;   // no idling on either side in this window
    localparam int QUIET_LAST     = 320;
    localparam int MAX_REPORTS    = 10;
    localparam coord_t UNIT       = coord_t'(1 << FRAC_BITS);  // 1.0 in Q16.16

    typedef longint field_row_t [12];

    string seg_field_name [12] = '{"seg_kind", "out_c1_x", "out_c1_y", "out_c2_x",
                                   "out_c2_y", "out_end_x", "out_end_y", "out_radius_x",
                                   "out_radius_y", "out_rotation", "out_large_arc",
                                   "out_sweep"};

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [TDATA_BITS-1:0] s_tdata  = '0;
    logic [CMD_WIDTH-1:0]  s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_BITS-1:0] m_tdata;
    logic [KIND_WIDTH-1:0] m_tuser;

    bit gaps_on = 1'b1;
    int stall_cycles = 0;

    svg_path_segment_normalizer_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 aclk = ~aclk;

    // Path state tracker: turns each accepted command into the absolute segment
    // the block should emit, and checks emitted segments in order.
    class segment_ledger;
        coord_t               cur_x, cur_y, start_x, start_y;
        coord_t               cubic_ctrl_x, cubic_ctrl_y, quad_ctrl_x, quad_ctrl_y;
        logic [FAM_WIDTH-1:0] prev_family;
        seg_t                 pending_segments [$];
        int                   faults;
        int                   commands_taken;
        int                   codes_ignored;
        int                   segments_checked;
        int                   kind_seen [6];

        function new();
            cur_x = COORD_ZERO;        cur_y = COORD_ZERO;
            start_x = COORD_ZERO;      start_y = COORD_ZERO;
            cubic_ctrl_x = COORD_ZERO; cubic_ctrl_y = COORD_ZERO;
            quad_ctrl_x = COORD_ZERO;  quad_ctrl_y = COORD_ZERO;
            prev_family = FAM_NONE;
            faults = 0;
            commands_taken = 0;
            codes_ignored = 0;
            segments_checked = 0;
            foreach (kind_seen[k]) kind_seen[k] = 0;
        endfunction

        static function coord_t pin(longint v);
            if (v > longint'(COORD_MAX)) return COORD_MAX;
            if (v < longint'(COORD_MIN)) return COORD_MIN;
            return coord_t'(v);
        endfunction

        static function coord_t offset_sat(coord_t base, coord_t delta);
            return pin(longint'(base) + longint'(delta));
        endfunction

        // control point mirrored through p: 2p - c
        static function coord_t mirror_sat(coord_t p, coord_t c);
            return pin(2 * longint'(p) - longint'(c));
        endfunction

        function bit normalize_command(input item_t it, output seg_t seg);
            logic [GRP_WIDTH-1:0] grp;
            logic [FAM_WIDTH-1:0] fam;
            coord_t               bx, by, c1x, c1y, c2x, c2y, ex, ey;
            seg = '0;
            if (it.cmd > CMD_LAST) return 1'b0;
            grp = it.cmd[CMD_WIDTH-1:1];
            bx  = it.cmd[0] ? cur_x : COORD_ZERO;
            by  = it.cmd[0] ? cur_y : COORD_ZERO;
            c1x = offset_sat(bx, it.ctrl1_x);
            c1y = offset_sat(by, it.ctrl1_y);
            c2x = offset_sat(bx, it.ctrl2_x);
            c2y = offset_sat(by, it.ctrl2_y);
            ex  = offset_sat(bx, it.end_x);
            ey  = offset_sat(by, it.end_y);
            fam = FAM_NONE;
            case (grp)
                GRP_MOVE: begin
                    seg.seg_kind = KIND_MOVE;
                    cur_x = ex; cur_y = ey;
                    start_x = ex; start_y = ey;
                end
                GRP_LINE: begin
                    seg.seg_kind = KIND_LINE;
                    cur_x = ex; cur_y = ey;
                end
                GRP_HORIZ: begin
                    seg.seg_kind = KIND_LINE;
                    cur_x = ex;
                end
                GRP_VERT: begin
                    seg.seg_kind = KIND_LINE;
                    cur_y = ey;
                end
                GRP_CUBIC: begin
                    seg.seg_kind = KIND_CUBIC;
                    seg.out_c1_x = c1x; seg.out_c1_y = c1y;
                    cubic_ctrl_x = c2x; cubic_ctrl_y = c2y;
                    cur_x = ex; cur_y = ey;
                    fam = FAM_CUBIC;
                end
                GRP_SCUBIC: begin
                    seg.seg_kind = KIND_CUBIC;
                    if (prev_family == FAM_CUBIC) begin
                        seg.out_c1_x = mirror_sat(cur_x, cubic_ctrl_x);
                        seg.out_c1_y = mirror_sat(cur_y, cubic_ctrl_y);
                    end else begin
                        seg.out_c1_x = cur_x; seg.out_c1_y = cur_y;
                    end
                    cubic_ctrl_x = c2x; cubic_ctrl_y = c2y;
                    cur_x = ex; cur_y = ey;
                    fam = FAM_CUBIC;
                end
                GRP_QUAD: begin
                    seg.seg_kind = KIND_QUAD;
                    quad_ctrl_x = c1x; quad_ctrl_y = c1y;
                    cur_x = ex; cur_y = ey;
                    fam = FAM_QUAD;
                end
                GRP_SQUAD: begin
                    seg.seg_kind = KIND_QUAD;
                    if (prev_family == FAM_QUAD) begin
                        quad_ctrl_x = mirror_sat(cur_x, quad_ctrl_x);
                        quad_ctrl_y = mirror_sat(cur_y, quad_ctrl_y);
                    end else begin
                        quad_ctrl_x = cur_x; quad_ctrl_y = cur_y;
                    end
                    cur_x = ex; cur_y = ey;
                    fam = FAM_QUAD;
                end
                GRP_ARC: begin
                    seg.seg_kind      = KIND_ARC;
                    seg.out_radius_x  = it.radius_x;
                    seg.out_radius_y  = it.radius_y;
                    seg.out_rotation  = it.rotation_angle;
                    seg.out_large_arc = it.large_arc;
                    seg.out_sweep     = it.sweep_cw;
                    cur_x = ex; cur_y = ey;
                end
                default: begin
                    seg.seg_kind = KIND_CLOSE;
                    cur_x = start_x; cur_y = start_y;
                end
            endcase
            if (seg.seg_kind == KIND_CUBIC) begin
                seg.out_c2_x = cubic_ctrl_x; seg.out_c2_y = cubic_ctrl_y;
            end
            if (seg.seg_kind == KIND_QUAD) begin
                seg.out_c1_x = quad_ctrl_x; seg.out_c1_y = quad_ctrl_y;
            end
            seg.out_end_x = cur_x;
            seg.out_end_y = cur_y;
            prev_family = fam;
            return 1'b1;
        endfunction

        function void note_command(item_t it);
            seg_t seg;
            commands_taken++;
            if (normalize_command(it, seg))
                pending_segments.push_back(seg);
            else
                codes_ignored++;
        endfunction

        static function field_row_t spread(seg_t s);
            field_row_t v;
            v[0]  = s.seg_kind;
            v[1]  = s.out_c1_x;     v[2] = s.out_c1_y;
            v[3]  = s.out_c2_x;     v[4] = s.out_c2_y;
            v[5]  = s.out_end_x;    v[6] = s.out_end_y;
            v[7]  = s.out_radius_x; v[8] = s.out_radius_y;
            v[9]  = s.out_rotation;
            v[10] = s.out_large_arc;
            v[11] = s.out_sweep;
            return v;
        endfunction

        function void check_segment(logic [KIND_WIDTH-1:0] kind, logic [TDATA_BITS-1:0] data);
            seg_t       got, want;
            field_row_t got_v, want_v;
            got.seg_kind      = kind;
            got.out_c1_x      = data[0*COORD_WIDTH +: COORD_WIDTH];
            got.out_c1_y      = data[1*COORD_WIDTH +: COORD_WIDTH];
            got.out_c2_x      = data[2*COORD_WIDTH +: COORD_WIDTH];
            got.out_c2_y      = data[3*COORD_WIDTH +: COORD_WIDTH];
            got.out_end_x     = data[4*COORD_WIDTH +: COORD_WIDTH];
            got.out_end_y     = data[5*COORD_WIDTH +: COORD_WIDTH];
            got.out_radius_x  = data[6*COORD_WIDTH +: COORD_WIDTH];
            got.out_radius_y  = data[7*COORD_WIDTH +: COORD_WIDTH];
            got.out_rotation  = data[8*COORD_WIDTH +: COORD_WIDTH];
            got.out_large_arc = data[9*COORD_WIDTH];
            got.out_sweep     = data[9*COORD_WIDTH + 1];
            if (pending_segments.size() == 0) begin
                if (faults < MAX_REPORTS)
                    $display("mismatch: segment kind %0d arrived with none outstanding", kind);
                faults++;
                return;
            end
            want = pending_segments.pop_front();
            segments_checked++;
            if (want.seg_kind < 6) kind_seen[want.seg_kind]++;
            got_v  = spread(got);
            want_v = spread(want);
            for (int f = 0; f < 12; f++) begin
                if (got_v[f] != want_v[f]) begin
                    if (faults < MAX_REPORTS)
                        $display("mismatch: segment %0d %0s expected %0d got %0d",
                                 segments_checked, seg_field_name[f], want_v[f], got_v[f]);
                    faults++;
                end
            end
        endfunction
    endclass

    segment_ledger ledger;

    function automatic logic [CMD_WIDTH-1:0] code_of(logic [GRP_WIDTH-1:0] grp, int rel);
        return {grp, rel[0]};
    endfunction

    // raw words half the time, else modest Q16.16 values or the range ends
    function automatic coord_t rand_coord();
        case ($urandom_range(0, 15))
            0:             return COORD_MAX;
            1:             return COORD_MIN;
            2:             return COORD_ZERO;
            3, 4, 5, 6, 7: return coord_t'(int'($urandom_range(0, 196608000)) - 98304000);
            default:       return coord_t'($urandom);
        endcase
    endfunction

    function automatic item_t random_command(logic [CMD_WIDTH-1:0] cmd);
        item_t it;
        it.cmd            = cmd;
        it.ctrl1_x        = rand_coord();
        it.ctrl1_y        = rand_coord();
        it.ctrl2_x        = rand_coord();
        it.ctrl2_y        = rand_coord();
        it.end_x          = rand_coord();
        it.end_y          = rand_coord();
        it.radius_x       = rand_coord();
        it.radius_y       = rand_coord();
        it.rotation_angle = rand_coord();
        it.large_arc      = 1'($urandom_range(0, 1));
        it.sweep_cw       = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // Offer one item and hold it until the block takes it; idle first at random while gaps are on.
    task automatic send_command(item_t it);
        logic [TDATA_BITS-1:0] word;
        word = '0;
        word[0*COORD_WIDTH +: COORD_WIDTH] = it.ctrl1_x;
        word[1*COORD_WIDTH +: COORD_WIDTH] = it.ctrl1_y;
        word[2*COORD_WIDTH +: COORD_WIDTH] = it.ctrl2_x;
        word[3*COORD_WIDTH +: COORD_WIDTH] = it.ctrl2_y;
        word[4*COORD_WIDTH +: COORD_WIDTH] = it.end_x;
        word[5*COORD_WIDTH +: COORD_WIDTH] = it.end_y;
        word[6*COORD_WIDTH +: COORD_WIDTH] = it.radius_x;
        word[7*COORD_WIDTH +: COORD_WIDTH] = it.radius_y;
        word[8*COORD_WIDTH +: COORD_WIDTH] = it.rotation_angle;
        word[9*COORD_WIDTH]                = it.large_arc;
        word[9*COORD_WIDTH + 1]            = it.sweep_cw;
        while (gaps_on && $urandom_range(0, 99) < 19) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.cmd;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        ledger.note_command(it);
    endtask

    // Directed item: chosen geometry, random arc data.
    task automatic issue(logic [GRP_WIDTH-1:0] grp, int rel, coord_t c1x, coord_t c1y,
                         coord_t c2x, coord_t c2y, coord_t ex, coord_t ey);
        item_t it;
        it = random_command(code_of(grp, rel));
        it.ctrl1_x = c1x; it.ctrl1_y = c1y;
        it.ctrl2_x = c2x; it.ctrl2_y = c2y;
        it.end_x   = ex;  it.end_y   = ey;
        send_command(it);
    endtask

    // Drawing command that favors smooth continuations after a curve.
    function automatic logic [GRP_WIDTH-1:0] next_draw(logic [GRP_WIDTH-1:0] prev_grp);
        if ((prev_grp == GRP_CUBIC || prev_grp == GRP_SCUBIC) && $urandom_range(0, 1))
            return GRP_SCUBIC;
        if ((prev_grp == GRP_QUAD || prev_grp == GRP_SQUAD) && $urandom_range(0, 1))
            return GRP_SQUAD;
        return 4'($urandom_range(GRP_LINE, GRP_ARC));
    endfunction

    task automatic run_subpath();
        logic [GRP_WIDTH-1:0] grp;
        int                   draws;
        grp   = GRP_MOVE;
        draws = $urandom_range(2, 14);
        // a few subpaths start drawing without a move
        if ($urandom_range(0, 9) != 0)
            send_command(random_command(code_of(GRP_MOVE, $urandom_range(0, 1))));
        for (int n = 0; n < draws; n++) begin
            gaps_on = !(ledger.commands_taken >= QUIET_FIRST &&
                        ledger.commands_taken <= QUIET_LAST);
            case ($urandom_range(0, 99))
                0, 1, 2, 3, 4, 5: begin
                    // unknown codes must leave the path state alone
                    send_command(random_command(5'($urandom_range(CMD_LAST + 1, 31))));
                end
                6, 7, 8, 9: begin
                    grp = GRP_CLOSE;
                    send_command(random_command(code_of(grp, $urandom_range(0, 1))));
                end
                10, 11, 12: begin
                    grp = GRP_MOVE;
                    send_command(random_command(code_of(grp, $urandom_range(0, 1))));
                end
                default: begin
                    grp = next_draw(grp);
                    send_command(random_command(code_of(grp, $urandom_range(0, 1))));
                end
            endcase
        end
        if ($urandom_range(0, 1))
            send_command(random_command(code_of(GRP_CLOSE, $urandom_range(0, 1))));
    endtask

    // Sink: check each accepted segment, then stall at random for the next cycle.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            ledger.check_segment(m_tuser, m_tdata);
        m_tready <= !(gaps_on && $urandom_range(0, 99) < 19);
    end

    // Watchdog: end the run if nothing moves on either side for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("[svg_path_segment_normalizer_top] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        item_t it;
        ledger = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: range ends, every command, smooth-curve corner cases.
        issue(GRP_MOVE,   0, '0, '0, '0, '0, COORD_MAX, COORD_MIN);
        issue(GRP_LINE,   1, '0, '0, '0, '0, UNIT, -UNIT);             // saturates both ways
        issue(GRP_MOVE,   1, '0, '0, '0, '0, COORD_MIN, COORD_MAX);    // lands on (-1, -1) in raw LSBs
        issue(GRP_LINE,   0, '0, '0, '0, '0, COORD_ZERO, COORD_ZERO);
        issue(GRP_SCUBIC, 0, '0, '0, UNIT, UNIT, 2 * UNIT, UNIT);      // smooth after a line
        issue(GRP_HORIZ,  1, '0, '0, '0, '0, 5 * UNIT, COORD_MAX);
        issue(GRP_HORIZ,  0, '0, '0, '0, '0, COORD_MIN, COORD_ZERO);
        issue(GRP_VERT,   1, '0, '0, '0, '0, COORD_ZERO, COORD_MIN);
        issue(GRP_VERT,   0, '0, '0, '0, '0, COORD_MIN, COORD_MAX);
        issue(GRP_CUBIC,  0, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
        issue(GRP_SCUBIC, 1, '0, '0, -UNIT, UNIT, -UNIT, UNIT);        // reflection saturates
        issue(GRP_SCUBIC, 0, '0, '0, 3 * UNIT, 4 * UNIT, UNIT, UNIT);
        issue(GRP_SQUAD,  1, '0, '0, '0, '0, UNIT, UNIT);              // smooth quad after cubic
        issue(GRP_CUBIC,  1, UNIT, -UNIT, 2 * UNIT, 2 * UNIT, 3 * UNIT, COORD_ZERO);
        issue(GRP_QUAD,   0, COORD_MAX, COORD_MIN, '0, '0, COORD_MIN, COORD_MAX);
        issue(GRP_SQUAD,  0, '0, '0, '0, '0, 7 * UNIT, -7 * UNIT);     // reflect pins at the ends
        issue(GRP_SQUAD,  1, '0, '0, '0, '0, UNIT, UNIT);              // reflect the reflection
        issue(GRP_QUAD,   1, -UNIT, UNIT, '0, '0, 2 * UNIT, -3 * UNIT);
        it = random_command(code_of(GRP_ARC, 0));
        it.radius_x = COORD_MAX; it.radius_y = COORD_MIN; it.rotation_angle = COORD_ZERO;
        it.large_arc = 1'b1; it.sweep_cw = 1'b0;
        send_command(it);
        it = random_command(code_of(GRP_ARC, 1));
        it.radius_x = COORD_MIN; it.radius_y = COORD_MAX; it.rotation_angle = -90 * UNIT;
        it.large_arc = 1'b0; it.sweep_cw = 1'b1;
        send_command(it);
        issue(GRP_CLOSE,  0, '0, '0, '0, '0, '0, '0);
        send_command(random_command(CMD_WIDTH'(CMD_LAST + 1)));
        send_command(random_command(5'h1F));
        issue(GRP_SQUAD,  0, '0, '0, '0, '0, UNIT, UNIT);              // smooth quad after close
        issue(GRP_CLOSE,  1, '0, '0, '0, '0, '0, '0);

        // Random paths until enough segments have been produced.
        while (ledger.commands_taken - ledger.codes_ignored < SEGMENT_TARGET)
            run_subpath();
        s_tvalid <= 1'b0;
        gaps_on = 1'b1;

        // Drain outstanding segments, then give the pipe time to show strays.
        while (ledger.pending_segments.size() != 0) @(posedge aclk);
        repeat (TRAIL_CYCLES) @(posedge aclk);

        $display("covered %0d commands (%0d unknown codes dropped), %0d segments checked",
                 ledger.commands_taken, ledger.codes_ignored, ledger.segments_checked);
        $display("segment kinds move/line/cubic/quad/arc/close: %0d/%0d/%0d/%0d/%0d/%0d",
                 ledger.kind_seen[0], ledger.kind_seen[1], ledger.kind_seen[2],
                 ledger.kind_seen[3], ledger.kind_seen[4], ledger.kind_seen[5]);
        if (ledger.faults == 0 && ledger.pending_segments.size() == 0) begin
            $display("[svg_path_segment_normalizer_top] OK");
        end else begin
            $display("%0d mismatches", ledger.faults);
            $display("[svg_path_segment_normalizer_top] ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
